### design/lea_pkg.sv
// LEA cipher package: constants, round-key type and helper functions.
// No dependencies; used by the interfaces and all design modules.
`timescale 1ns / 1ps
package lea_pkg;

    localparam int unsigned MAX_ROUNDS = 32;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECRYPT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_01   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_23   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_45   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_67   = 3'd5;

    localparam logic [1:0] KSEL_192 = 2'd1;
    localparam logic [1:0] KSEL_256 = 2'd2;

    typedef logic [31:0] word_t;
    typedef word_t [5:0] rkey_t;
    typedef word_t [3:0] blk_t;

    typedef struct packed {
        word_t block_word0;
        word_t block_word1;
        word_t block_word2;
        word_t block_word3;
    } in_item_t;

    typedef struct packed {
        word_t out_word0;
        word_t out_word1;
        word_t out_word2;
        word_t out_word3;
    } out_item_t;

    function automatic word_t delta(input logic [2:0] i);
        word_t d;
        case (i)
            3'd0:    d = 32'hc3efe9db;
            3'd1:    d = 32'h44626b02;
            3'd2:    d = 32'h79e27c8a;
            3'd3:    d = 32'h78df30ec;
            3'd4:    d = 32'h715ea49e;
            3'd5:    d = 32'hc785da0a;
            3'd6:    d = 32'he04ef22a;
            default: d = 32'he5c40957;
        endcase
        return d;
    endfunction

    function automatic word_t rol(input word_t x, input logic [4:0] n);
        logic [63:0] t;
        t = {x, x} << n;
        return t[63:32];
    endfunction

    function automatic word_t bswap(input word_t x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    function automatic blk_t enc_round(input blk_t x, input rkey_t r);
        blk_t y;
        y[0] = rol((x[0] ^ r[0]) + (x[1] ^ r[1]), 5'd9);
        y[1] = rol((x[1] ^ r[2]) + (x[2] ^ r[3]), 5'd27);
        y[2] = rol((x[2] ^ r[4]) + (x[3] ^ r[5]), 5'd29);
        y[3] = x[0];
        return y;
    endfunction

    function automatic blk_t dec_round(input blk_t x, input rkey_t r);
        blk_t y;
        y[0] = x[3];
        y[1] = (rol(x[0], 5'd23) - (y[0] ^ r[0])) ^ r[1];
        y[2] = (rol(x[1], 5'd5) - (y[1] ^ r[2])) ^ r[3];
        y[3] = (rol(x[2], 5'd3) - (y[2] ^ r[4])) ^ r[5];
        return y;
    endfunction

endpackage

### design/lea_ifs.sv
// Valid/ready stream interfaces for blocks, results and configuration.
// Depends on lea_pkg.
`timescale 1ns / 1ps
interface lea_in_if;
    logic             valid;
    logic             ready;
    lea_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lea_out_if;
    logic              valid;
    logic              ready;
    lea_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lea_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [lea_pkg::CFG_IDX_W-1:0]       index;
    logic [lea_pkg::CFG_DATA_W-1:0]      wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

### design/lea_ksched.sv
// Round-key table: expands the configured key into 32 round keys after
// each start. Depends on lea_pkg.
`timescale 1ns / 1ps
module lea_ksched
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [1:0]           key_size_select,
    input  logic [255:0]         key,
    output lea_pkg::rkey_t [lea_pkg::MAX_ROUNDS-1:0] rk,
    output logic                 busy
);
    lea_pkg::word_t [7:0] t_reg, t_next;
    lea_pkg::rkey_t       rnd;
    lea_pkg::rkey_t [lea_pkg::MAX_ROUNDS-1:0] rk_reg;
    logic [4:0] i_reg;
    logic [2:0] ph_reg;   // (i*6) % nk for 6- and 8-word keys
    logic [2:0] di_reg;   // i % nk
    logic       busy_reg;
    logic [3:0] nk;
    logic [2:0] p;
    lea_pkg::word_t d;

    // x is below 2*n wherever the result is used, so one subtract wraps it
    function automatic logic [2:0] wrap_nk(input logic [3:0] x, input logic [3:0] n);
        logic [3:0] y;
        y = (x >= n) ? x - n : x;
        return y[2:0];
    endfunction

    always_comb
    begin
        case (key_size_select)
            lea_pkg::KSEL_192: nk = 4'd6;
            lea_pkg::KSEL_256: nk = 4'd8;
            default:           nk = 4'd4;
        endcase
    end

    always_comb
    begin
        t_next = t_reg;
        rnd = '0;
        p = '0;
        d = lea_pkg::delta(di_reg);
        if (nk == 4'd4) begin
            t_next[0] = lea_pkg::rol(t_reg[0] + lea_pkg::rol(d, i_reg), 5'd1);
            t_next[1] = lea_pkg::rol(t_reg[1] + lea_pkg::rol(d, i_reg + 5'd1), 5'd3);
            t_next[2] = lea_pkg::rol(t_reg[2] + lea_pkg::rol(d, i_reg + 5'd2), 5'd6);
            t_next[3] = lea_pkg::rol(t_reg[3] + lea_pkg::rol(d, i_reg + 5'd3), 5'd11);
            rnd = {t_next[1], t_next[3], t_next[1], t_next[2], t_next[1], t_next[0]};
        end else begin
            for (int j = 0; j < 6; j++) begin
                p = wrap_nk(4'(ph_reg) + 4'(j), nk);
                t_next[p] = lea_pkg::rol(t_reg[p] + lea_pkg::rol(d, i_reg + 5'(j)),
                    (j == 0) ? 5'd1 : (j == 1) ? 5'd3 : (j == 2) ? 5'd6 :
                    (j == 3) ? 5'd11 : (j == 4) ? 5'd13 : 5'd17);
                rnd[j] = t_next[p];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            i_reg    <= '0;
            ph_reg   <= '0;
            di_reg   <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            i_reg    <= '0;
            ph_reg   <= '0;
            di_reg   <= '0;
        end else if (busy_reg) begin
            i_reg    <= i_reg + 5'd1;
            busy_reg <= (i_reg != 5'd31);
            ph_reg   <= wrap_nk(4'(ph_reg) + 4'd6, nk);
            di_reg   <= wrap_nk(4'(di_reg) + 4'd1, nk);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start) begin
            for (int j = 0; j < 8; j++)
                t_reg[j] <= (4'(j) < nk) ? lea_pkg::bswap(key[32*j +: 32]) : '0;
        end else if (busy_reg) begin
            t_reg <= t_next;
            rk_reg[i_reg] <= rnd;
        end
    end

    assign rk   = rk_reg;
    assign busy = busy_reg;
endmodule

### design/lea_block_cipher.sv
// LEA block cipher top level: config registers, key schedule and a fully
// unrolled round pipeline. Depends on lea_pkg, lea_ifs, lea_ksched.
`timescale 1ns / 1ps
// Usage:
//   cfg  : write words (index, wdata). 0 key size, 1 decrypt, 2..5 key words.
//          A write to the key size or a key word restarts the key expansion;
//          blocks are held off (in.ready low) meanwhile.
//   in   : one 128-bit block per word, words byte-swapped on entry.
//   out  : one result block per input block, in order.
//   Throughput is one block per cycle while the output is not stalled and no
//   key expansion runs. A block passes an input register that does the entry
//   byte swap, then one stage per round (32 stages; 128-bit keys use 24 real
//   rounds and pass through the rest); the exit byte swap is combinational.
//   Shorter key sizes bypass unused stages at their head, so latency is the
//   same for every key size.
//   Reset clears the config registers (128-bit zero key, encrypt) and starts
//   a key expansion. When out.ready is low while out.valid is high the whole
//   pipeline holds; no word is lost or repeated, and in.ready drops with it.
module lea_block_cipher
(
    input  logic       clk,
    input  logic       rst_n,
    lea_cfg_if.sink    cfg,
    lea_in_if.sink     in,
    lea_out_if.source  out
);
    localparam int unsigned NR     = lea_pkg::MAX_ROUNDS;
    localparam int unsigned STAGES = lea_pkg::MAX_ROUNDS;

    logic [1:0]   key_size_reg;
    logic         decrypt_reg;
    logic [255:0] key_reg;
    logic         start_reg;
    logic         ks_busy;
    logic         cfg_wr;
    lea_pkg::rkey_t [NR-1:0] rk;
    logic [5:0]   nr;

    lea_pkg::blk_t [STAGES:0] x_reg;
    logic [STAGES:0]          v_reg;
    logic                     adv;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            key_size_reg <= '0;
            decrypt_reg  <= 1'b0;
            key_reg      <= '0;
            start_reg    <= 1'b1;
        end else begin
            start_reg <= 1'b0;
            if (cfg_wr) begin
                case (cfg.index)
                    lea_pkg::REG_KEY_SIZE: begin
                        key_size_reg <= cfg.wdata[1:0];
                        start_reg    <= 1'b1;
                    end
                    lea_pkg::REG_DECRYPT: decrypt_reg <= cfg.wdata[0];
                    lea_pkg::REG_KEY_01: begin
                        key_reg[63:0] <= cfg.wdata;
                        start_reg     <= 1'b1;
                    end
                    lea_pkg::REG_KEY_23: begin
                        key_reg[127:64] <= cfg.wdata;
                        start_reg       <= 1'b1;
                    end
                    lea_pkg::REG_KEY_45: begin
                        key_reg[191:128] <= cfg.wdata;
                        start_reg        <= 1'b1;
                    end
                    lea_pkg::REG_KEY_67: begin
                        key_reg[255:192] <= cfg.wdata;
                        start_reg        <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    lea_ksched u_ksched (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start_reg),
        .key_size_select (key_size_reg),
        .key             (key_reg),
        .rk              (rk),
        .busy            (ks_busy)
    );

    always_comb
    begin
        case (key_size_reg)
            lea_pkg::KSEL_192: nr = 6'd28;
            lea_pkg::KSEL_256: nr = 6'd32;
            default:           nr = 6'd24;
        endcase
    end

    assign adv      = out.ready || !v_reg[STAGES];
    assign in.ready = adv && !ks_busy && !start_reg;

    // Stage s runs round s - (STAGES - nr) when active; earlier stages pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[STAGES-1:0], in.valid && in.ready};
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            x_reg[0] <= {lea_pkg::bswap(in.data.block_word3),
                         lea_pkg::bswap(in.data.block_word2),
                         lea_pkg::bswap(in.data.block_word1),
                         lea_pkg::bswap(in.data.block_word0)};
            for (int s = 0; s < STAGES; s++) begin
                if (7'(s) + 7'(nr) < 7'(STAGES))
                    x_reg[s+1] <= x_reg[s];
                else if (!decrypt_reg)
                    x_reg[s+1] <= lea_pkg::enc_round(x_reg[s],
                        rk[5'(7'(s) + 7'(nr) - 7'(STAGES))]);
                else
                    x_reg[s+1] <= lea_pkg::dec_round(x_reg[s],
                        rk[5'(7'(STAGES) - 7'd1 - 7'(s))]);
            end
        end
    end

    assign out.valid          = v_reg[STAGES];
    assign out.data.out_word0 = lea_pkg::bswap(x_reg[STAGES][0]);
    assign out.data.out_word1 = lea_pkg::bswap(x_reg[STAGES][1]);
    assign out.data.out_word2 = lea_pkg::bswap(x_reg[STAGES][2]);
    assign out.data.out_word3 = lea_pkg::bswap(x_reg[STAGES][3]);

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ks_busy |-> !in.ready) else $error("block taken during key expansion");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out.valid && !out.ready |=> out.valid && $stable(x_reg[STAGES]))
        else $error("result changed under stall");
    a_stall_adv: assert property (@(posedge clk) disable iff (!rst_n)
        out.valid && !out.ready |-> !in.ready) else $error("accept during stall");
endmodule
